// ===== design/dqb_pkg.sv =====
// Shared types, constants and register map of the DNS query packet builder.
package dqb_pkg;

  localparam int PACKET_BYTES_DEF = 512;
  localparam int MAX_RESULTS      = 13;
  localparam int HEADER_BYTES     = 12;
  localparam int MAX_LABEL        = 63;
  localparam int APB_AW           = 4;
  localparam int APB_DW           = 32;

  localparam logic [3:0] OPCODE_QUERY = 4'h0;
  localparam logic [7:0] CHAR_DOT     = 8'h2e;
  localparam logic [7:0] CHAR_ESC     = 8'h5c;

  localparam logic [15:0] QTYPE_RESET  = 16'd1;
  localparam logic [15:0] QCLASS_RESET = 16'd1;
  localparam logic        RD_RESET     = 1'b1;

  localparam logic [1:0] REG_QUERY_TYPE  = 2'd0;
  localparam logic [1:0] REG_QUERY_CLASS = 2'd1;
  localparam logic [1:0] REG_RECURSION   = 2'd2;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_LABEL    = 2'd1,
    ERR_OVERFLOW = 2'd2
  } err_t;

  typedef struct packed {
    logic       we;
    logic [8:0] off;
    logic [7:0] val;
    err_t       err;
  } res_t;

endpackage

// ===== design/dqb_name_if.sv =====
// Host name character channel.
interface dqb_name_if;
  logic        valid;
  logic        ready;
  logic [7:0]  name_char;
  logic        first_char;
  logic        last_char;
  logic [15:0] query_id;

  modport source (output valid, name_char, first_char, last_char, query_id, input ready);
  modport sink (input valid, name_char, first_char, last_char, query_id, output ready);
endinterface

// ===== design/dqb_write_if.sv =====
// Packet byte write channel.
interface dqb_write_if;
  logic       valid;
  logic       ready;
  logic       write_enable;
  logic [8:0] byte_offset;
  logic [7:0] byte_value;
  logic       run_last;
  logic       packet_done;
  logic [9:0] packet_length;
  logic [1:0] name_error;

  modport source (output valid, write_enable, byte_offset, byte_value, run_last,
                  packet_done, packet_length, name_error, input ready);
  modport sink (input valid, write_enable, byte_offset, byte_value, run_last,
                packet_done, packet_length, name_error, output ready);
endinterface

// ===== design/dns_query_packet_builder_top.sv =====
// Usage:
// name_stream carries one host name character per request, with first_char
// opening a new name (query_id taken there) and last_char closing it.
// write_stream returns the packet byte writes each request causes, one per
// cycle while write_stream.ready is high, run_last marking the final one of
// the request. A request that writes nothing returns one status result with
// write_enable low. packet_done and packet_length appear on the final result
// of a name that closed cleanly; name_error reports a label over 63 bytes or a
// packet over PACKET_BYTES. A request is held in an input register, turned
// combinationally into its whole result list and loaded into the single
// output shift buffer, which offers the results from entry 0: one for an
// ordinary character, 12 or 13 for a first character (header burst), up to 7
// for a last one. The input register takes a new request while results still
// wait, so a stalled receiver holds the buffer and back-pressure reaches
// name_stream only once that register is full.
// Synchronous reset closes any open name, empties both stages and sets
// query_type 1, query_class 1, recursion_desired 1. APB writes are taken
// in the access cycle; registers sit at byte addresses 0, 4 and 8.
module dns_query_packet_builder_top #(
  parameter int PACKET_BYTES = dqb_pkg::PACKET_BYTES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  dqb_name_if.sink                   name_stream,
  dqb_write_if.source                write_stream,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [dqb_pkg::APB_AW-1:0] paddr,
  input  logic [dqb_pkg::APB_DW-1:0] pwdata,
  output logic [dqb_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);
  import dqb_pkg::*;

  localparam int WPW = $clog2(PACKET_BYTES + 8);
  localparam int CW  = $clog2(MAX_RESULTS + 1);
  localparam logic [WPW-1:0] PB_LIMIT = WPW'(PACKET_BYTES);

  // configuration
  logic [15:0] query_type;
  logic [15:0] query_class;
  logic        recursion_desired;
  logic        cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      query_type        <= QTYPE_RESET;
      query_class       <= QCLASS_RESET;
      recursion_desired <= RD_RESET;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_QUERY_TYPE:  query_type        <= pwdata[15:0];
        REG_QUERY_CLASS: query_class       <= pwdata[15:0];
        REG_RECURSION:   recursion_desired <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_QUERY_TYPE:  prdata = {16'b0, query_type};
      REG_QUERY_CLASS: prdata = {16'b0, query_class};
      REG_RECURSION:   prdata = {31'b0, recursion_desired};
      default:         prdata = '0;
    endcase
  end

  // input register
  logic        p_valid;
  logic [7:0]  p_char;
  logic        p_first;
  logic        p_last;
  logic [15:0] p_id;

  // name state
  logic [WPW-1:0] write_pos, write_pos_next;
  logic [WPW-1:0] length_slot, length_slot_next;
  logic [5:0]     label_len, label_len_next;
  logic           escape_pending, escape_pending_next;
  err_t           error_code, error_code_next;

  // result buffer
  res_t           rbuf [MAX_RESULTS];
  logic [CW-1:0]  rcnt;
  logic           done_r;
  logic [9:0]     len_r;

  res_t           lst [MAX_RESULTS];
  logic [CW-1:0]  lst_n;
  logic           done_next;
  logic [9:0]     len_next;

  logic load, pop, in_take;

  assign pop     = write_stream.valid && write_stream.ready;
  assign load    = p_valid && (rcnt == '0 || (rcnt == CW'(1) && write_stream.ready));
  assign name_stream.ready = !p_valid || load;
  assign in_take = name_stream.valid && name_stream.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (in_take) begin
      p_valid <= 1'b1;
    end else if (load) begin
      p_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      p_char  <= name_stream.name_char;
      p_first <= name_stream.first_char;
      p_last  <= name_stream.last_char;
      p_id    <= name_stream.query_id;
    end
  end

  // build the full result list of the held request
  always_comb begin
    logic [WPW-1:0] wp, ls, wb;
    logic [5:0]     ll;
    logic           esc, closing;
    err_t           err, err_before;
    logic [CW-1:0]  n;
    logic [WPW-1:0] cpos [6];
    logic [7:0]     cval [6];
    logic [5:0]     cuse;

    for (int i = 0; i < MAX_RESULTS; i++) begin
      lst[i] = '0;
    end
    wp         = write_pos;
    ls         = length_slot;
    ll         = label_len;
    esc        = escape_pending;
    err        = error_code;
    err_before = error_code;
    n          = '0;
    wb         = '0;
    closing    = p_last;
    done_next  = 1'b0;
    len_next   = '0;
    for (int i = 0; i < 6; i++) begin
      cpos[i] = '0;
      cval[i] = '0;
    end
    cuse = '0;

    if (p_first) begin
      err        = ERR_NONE;
      err_before = ERR_NONE;
      esc        = 1'b0;
      ll         = '0;
      for (int i = 0; i < HEADER_BYTES; i++) begin
        lst[i].we  = 1'b1;
        lst[i].off = 9'(i);
        lst[i].err = ERR_NONE;
      end
      lst[0].val = p_id[15:8];
      lst[1].val = p_id[7:0];
      lst[2].val = {1'b0, OPCODE_QUERY, 2'b00, recursion_desired};
      lst[5].val = 8'd1;
      n       = CW'(HEADER_BYTES);
      ls      = WPW'(HEADER_BYTES);
      wp      = WPW'(HEADER_BYTES + 1);
      closing = 1'b0;
    end

    if (wp != '0 && err == ERR_NONE) begin
      if (!esc && p_char == CHAR_ESC) begin
        esc = 1'b1;
      end else if (!esc && p_char == CHAR_DOT) begin
        if (ll != '0) begin
          // back-patch the label length, then reserve the next slot
          if (ls >= PB_LIMIT) begin
            err = ERR_OVERFLOW;
          end else begin
            lst[n] = '{we: 1'b1, off: 9'(ls), val: {2'b00, ll}, err: ERR_NONE};
            n  = n + CW'(1);
            ls = wp;
            wp = wp + WPW'(1);
            ll = '0;
          end
        end
      end else begin
        esc = 1'b0;
        if (ll == 6'(MAX_LABEL)) begin
          err = ERR_LABEL;
        end else if (wp >= PB_LIMIT) begin
          err = ERR_OVERFLOW;
        end else begin
          lst[n] = '{we: 1'b1, off: 9'(wp), val: p_char, err: ERR_NONE};
          n  = n + CW'(1);
          wp = wp + WPW'(1);
          ll = ll + 6'd1;
        end
      end
    end

    if (closing && wp != '0) begin
      if (err == ERR_NONE) begin
        cuse    = 6'b111111;
        cpos[0] = ls;
        if (ll != '0) begin
          cval[0] = {2'b00, ll};
          cpos[1] = wp;
          wb      = wp + WPW'(1);
        end else begin
          cuse[1] = 1'b0;
          wb      = wp;
        end
        cpos[2] = wb;
        cpos[3] = wb + WPW'(1);
        cpos[4] = wb + WPW'(2);
        cpos[5] = wb + WPW'(3);
        cval[2] = query_type[15:8];
        cval[3] = query_type[7:0];
        cval[4] = query_class[15:8];
        cval[5] = query_class[7:0];
        for (int i = 0; i < 6; i++) begin
          if (cuse[i] && err == ERR_NONE) begin
            if (cpos[i] >= PB_LIMIT) begin
              err = ERR_OVERFLOW;
            end else begin
              lst[n] = '{we: 1'b1, off: 9'(cpos[i]), val: cval[i], err: ERR_NONE};
              n = n + CW'(1);
            end
          end
        end
        if (err == ERR_NONE) begin
          done_next = 1'b1;
          len_next  = 10'(wb + WPW'(4));
        end
      end
      wp  = '0;
      ls  = '0;
      ll  = '0;
      esc = 1'b0;
    end

    // status result when nothing was written or the error changed
    if (n == '0 || err != err_before) begin
      lst[n] = '{we: 1'b0, off: 9'd0, val: 8'd0, err: err};
      n = n + CW'(1);
    end

    lst_n               = n;
    write_pos_next      = wp;
    length_slot_next    = ls;
    label_len_next      = ll;
    escape_pending_next = esc;
    error_code_next     = err;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_pos      <= '0;
      length_slot    <= '0;
      label_len      <= '0;
      escape_pending <= 1'b0;
      error_code     <= ERR_NONE;
      rcnt           <= '0;
    end else if (load) begin
      write_pos      <= write_pos_next;
      length_slot    <= length_slot_next;
      label_len      <= label_len_next;
      escape_pending <= escape_pending_next;
      error_code     <= error_code_next;
      rcnt           <= lst_n;
    end else if (pop) begin
      rcnt <= rcnt - CW'(1);
    end
  end

  // shift the result list out from entry 0
  always_ff @(posedge clk) begin
    if (load) begin
      rbuf   <= lst;
      done_r <= done_next;
      len_r  <= len_next;
    end else if (pop) begin
      for (int i = 0; i < MAX_RESULTS - 1; i++) begin
        rbuf[i] <= rbuf[i+1];
      end
    end
  end

  logic on_last;
  assign on_last = (rcnt == CW'(1));

  assign write_stream.valid         = (rcnt != '0);
  assign write_stream.write_enable  = rbuf[0].we;
  assign write_stream.byte_offset   = rbuf[0].off;
  assign write_stream.byte_value    = rbuf[0].val;
  assign write_stream.run_last      = on_last;
  assign write_stream.packet_done   = on_last && done_r;
  assign write_stream.packet_length = (on_last && done_r) ? len_r : 10'd0;
  assign write_stream.name_error    = rbuf[0].err;

endmodule
